// ===== src/darp_pkg.sv =====
package darp_pkg;

    // One accepted request: a payload byte and its start mark
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       start_of_message;
    } darp_item_t;

    // One parse result
    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  server_rcode;
        logic [31:0] host_addr;
    } darp_result_t;

    // Result status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_NOT_RESPONSE = 3'd1;
    localparam logic [2:0] ST_WRONG_IDENT  = 3'd2;
    localparam logic [2:0] ST_SERVER_RCODE = 3'd3;
    localparam logic [2:0] ST_ANSWER_COUNT = 3'd4;
    localparam logic [2:0] ST_BAD_ANSWER   = 3'd5;

    // Parser phases, one-hot
    typedef enum logic [8:0] {
        PH_HEADER = 9'b000000001,
        PH_QNAME  = 9'b000000010,
        PH_QFOOT  = 9'b000000100,
        PH_ANAME  = 9'b000001000,
        PH_APTR   = 9'b000010000,
        PH_ASKIP  = 9'b000100000,
        PH_AFIXED = 9'b001000000,
        PH_RDATA  = 9'b010000000,
        PH_DONE   = 9'b100000000
    } darp_phase_t;

    // Byte positions inside the fixed-size parts
    localparam logic [3:0] HDR_IDENT_HI   = 4'd0;
    localparam logic [3:0] HDR_IDENT_LO   = 4'd1;
    localparam logic [3:0] HDR_FLAGS_HI   = 4'd2;
    localparam logic [3:0] HDR_FLAGS_LO   = 4'd3;
    localparam logic [3:0] HDR_ANCOUNT_HI = 4'd6;
    localparam logic [3:0] HDR_ANCOUNT_LO = 4'd7;
    localparam logic [3:0] HDR_LAST       = 4'd11;
    localparam logic [3:0] QFOOT_LAST     = 4'd3;
    localparam logic [3:0] AFIX_RDLEN_HI  = 4'd8;
    localparam logic [3:0] AFIX_RDLEN_LO  = 4'd9;

    // Name label prefix marking a compressed pointer
    localparam logic [1:0] NAME_POINTER = 2'b11;

    localparam logic [15:0] IDENT_RESET = 16'hDEAD;

endpackage

// ===== src/darp_in_stage.sv =====
module darp_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  darp_pkg::darp_item_t in_item,
    input  logic                 advance,
    output logic                 item_valid,
    output darp_pkg::darp_item_t item
);

    logic                 valid_reg;
    logic                 valid_next;
    darp_pkg::darp_item_t item_reg;

    // Take a new request whenever the held one is empty or moving on
    assign in_ready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload of the accepted request
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== src/darp_core.sv =====
module darp_core #(
    parameter int MAX_ANSWER_BYTES = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [15:0]            cfg_wdata,
    input  logic                   advance,
    input  darp_pkg::darp_item_t   item,
    output logic                   emit,
    output darp_pkg::darp_result_t result
);

    localparam int LW = $clog2(MAX_ANSWER_BYTES + 1);

    darp_pkg::darp_phase_t phase_reg, phase_next, phase_cur;
    logic [3:0]  idx_reg, idx_next, idx_cur;
    logic [15:0] expected_ident_reg;
    logic [15:0] ident_reg, ident_next;
    logic        qr_reg, qr_next;
    logic [3:0]  rcode_reg, rcode_next;
    logic [15:0] answers_reg, answers_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [LW-1:0] len_reg, len_next;
    logic [31:0] addr_reg, addr_next;
    logic [15:0] len_full;
    logic [4:0]  idx_inc;
    logic [7:0]  b;
    logic        found;

    assign b        = item.payload_byte;
    assign len_full = {len_hi_reg, b};
    assign idx_inc  = {1'b0, idx_cur} + 5'd1;

    // Step the parser by one byte
    always_comb
    begin
        phase_cur    = item.start_of_message ? darp_pkg::PH_HEADER : phase_reg;
        idx_cur      = item.start_of_message ? 4'd0 : idx_reg;
        phase_next   = phase_cur;
        idx_next     = idx_cur;
        ident_next   = ident_reg;
        qr_next      = qr_reg;
        rcode_next   = rcode_reg;
        answers_next = answers_reg;
        len_hi_next  = len_hi_reg;
        len_next     = len_reg;
        addr_next    = addr_reg;
        found        = 1'b0;
        result       = '0;

        case (phase_cur)
            darp_pkg::PH_HEADER:
            begin
                case (idx_cur)
                    darp_pkg::HDR_IDENT_HI:   ident_next = {b, 8'h00};
                    darp_pkg::HDR_IDENT_LO:   ident_next = {ident_reg[15:8], b};
                    darp_pkg::HDR_FLAGS_HI:   qr_next = b[7];
                    darp_pkg::HDR_FLAGS_LO:   rcode_next = b[3:0];
                    darp_pkg::HDR_ANCOUNT_HI: answers_next = {b, 8'h00};
                    darp_pkg::HDR_ANCOUNT_LO: answers_next = {answers_reg[15:8], b};
                    default: ;
                endcase
                idx_next = 4'(idx_cur + 4'd1);
                // Check the header in priority order on its last byte
                if (idx_cur == darp_pkg::HDR_LAST)
                begin
                    idx_next = 4'd0;
                    found    = 1'b1;
                    if (!qr_reg)
                    begin
                        result.status = darp_pkg::ST_NOT_RESPONSE;
                    end
                    else if (ident_reg != expected_ident_reg)
                    begin
                        result.status = darp_pkg::ST_WRONG_IDENT;
                    end
                    else if (rcode_reg != 4'd0)
                    begin
                        result.status       = darp_pkg::ST_SERVER_RCODE;
                        result.server_rcode = rcode_reg;
                    end
                    else if (answers_reg != 16'd1)
                    begin
                        result.status = darp_pkg::ST_ANSWER_COUNT;
                    end
                    else
                    begin
                        found      = 1'b0;
                        phase_next = darp_pkg::PH_QNAME;
                    end
                end
            end
            darp_pkg::PH_QNAME:
            begin
                if (b == 8'd0)
                begin
                    phase_next = darp_pkg::PH_QFOOT;
                    idx_next   = 4'd0;
                end
            end
            darp_pkg::PH_QFOOT:
            begin
                idx_next = 4'(idx_cur + 4'd1);
                if (idx_cur == darp_pkg::QFOOT_LAST)
                begin
                    idx_next   = 4'd0;
                    phase_next = darp_pkg::PH_ANAME;
                end
            end
            darp_pkg::PH_ANAME:
            begin
                idx_next = 4'd0;
                if (b[7:6] == darp_pkg::NAME_POINTER)
                begin
                    phase_next = darp_pkg::PH_APTR;
                end
                else if (b == 8'd0)
                begin
                    phase_next = darp_pkg::PH_AFIXED;
                end
                else
                begin
                    phase_next = darp_pkg::PH_ASKIP;
                end
            end
            darp_pkg::PH_APTR:
            begin
                idx_next   = 4'd0;
                phase_next = darp_pkg::PH_AFIXED;
            end
            darp_pkg::PH_ASKIP:
            begin
                if (b == 8'd0)
                begin
                    idx_next   = 4'd0;
                    phase_next = darp_pkg::PH_AFIXED;
                end
            end
            darp_pkg::PH_AFIXED:
            begin
                idx_next = 4'(idx_cur + 4'd1);
                if (idx_cur == darp_pkg::AFIX_RDLEN_HI)
                begin
                    len_hi_next = b;
                end
                // Judge the data length on the last fixed byte
                if (idx_cur == darp_pkg::AFIX_RDLEN_LO)
                begin
                    idx_next  = 4'd0;
                    addr_next = '0;
                    if (len_full > 16'(MAX_ANSWER_BYTES))
                    begin
                        found         = 1'b1;
                        result.status = darp_pkg::ST_BAD_ANSWER;
                    end
                    else if (len_full == 16'd0)
                    begin
                        found         = 1'b1;
                        result.status = darp_pkg::ST_OK;
                    end
                    else
                    begin
                        len_next   = len_full[LW-1:0];
                        phase_next = darp_pkg::PH_RDATA;
                    end
                end
            end
            darp_pkg::PH_RDATA:
            begin
                // Keep only the first four data bytes, most significant first
                if (idx_cur[3:2] == 2'b00)
                begin
                    case (idx_cur[1:0])
                        2'd0:    addr_next[31:24] = addr_reg[31:24] | b;
                        2'd1:    addr_next[23:16] = addr_reg[23:16] | b;
                        2'd2:    addr_next[15:8]  = addr_reg[15:8] | b;
                        default: addr_next[7:0]   = addr_reg[7:0] | b;
                    endcase
                end
                idx_next = 4'(idx_cur + 4'd1);
                if (idx_inc >= 5'(len_reg))
                begin
                    found            = 1'b1;
                    result.status    = darp_pkg::ST_OK;
                    result.host_addr = addr_next;
                end
            end
            default: ;
        endcase

        if (found)
        begin
            phase_next = darp_pkg::PH_DONE;
        end
    end

    assign emit = advance && found;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= darp_pkg::PH_HEADER;
            idx_reg            <= 4'd0;
            expected_ident_reg <= darp_pkg::IDENT_RESET;
        end
        else
        begin
            if (advance)
            begin
                phase_reg <= phase_next;
                idx_reg   <= idx_next;
            end
            if (cfg_we)
            begin
                expected_ident_reg <= cfg_wdata;
            end
        end
    end

    // Gathered header fields, length and address
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ident_reg   <= ident_next;
            qr_reg      <= qr_next;
            rcode_reg   <= rcode_next;
            answers_reg <= answers_next;
            len_hi_reg  <= len_hi_next;
            len_reg     <= len_next;
            addr_reg    <= addr_next;
        end
    end

    // A finished message stays quiet until the next start
    a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == darp_pkg::PH_DONE && !item.start_of_message) |-> !found)
        else $error("result produced after message was complete");

    // Every result closes the message
    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> phase_reg == darp_pkg::PH_DONE)
        else $error("parser did not close the message after a result");

    // Data byte count never passes the allowed length
    a_rdata_len: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == darp_pkg::PH_RDATA |-> 5'(idx_reg) < 5'(len_reg))
        else $error("data byte count ran past the answer length");

endmodule

// ===== src/darp_out_stage.sv =====
module darp_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  darp_pkg::darp_result_t result,
    output logic                   free,
    output logic                   out_valid,
    input  logic                   out_ready,
    output darp_pkg::darp_result_t out_result
);

    logic                   valid_reg;
    logic                   valid_next;
    darp_pkg::darp_result_t result_reg;

    // Room for a new result when empty or being taken now
    assign free       = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule

// ===== src/dns_a_record_response_parser.sv =====
// DNS A-record response parser.
// Input channel (in_valid/in_ready): one payload byte per request, with
// start_of_message high on the first header byte of each response.
// Output channel (out_valid/out_ready): at most one result per message:
// status, server_rcode and host_addr.
// Configuration: cfg_we writes cfg_wdata to the expected identification;
// write it only while no message is in flight.
// Result path: the byte that completes a result is held in the input
// register, and the result register loads from it once it has room.
// Throughput: one byte per cycle while out_ready stays high; the per-byte
// parser update is the only logic between the input and result registers.
// Reset: the expected identification returns to 0xDEAD, the parser waits
// for header byte 0, and both registers empty.
// Receiver stall: while a result waits with out_ready low the parser holds;
// the input register takes at most one more byte, then in_ready stays low
// until out_ready frees the result register.
module dns_a_record_response_parser #(
    parameter int MAX_ANSWER_BYTES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  payload_byte,
    input  logic        start_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [3:0]  server_rcode,
    output logic [31:0] host_addr,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    darp_pkg::darp_item_t   in_item;
    darp_pkg::darp_item_t   item;
    darp_pkg::darp_result_t result;
    darp_pkg::darp_result_t out_result;
    logic                   item_valid;
    logic                   free;
    logic                   advance;
    logic                   emit;

    assign in_item.payload_byte     = payload_byte;
    assign in_item.start_of_message = start_of_message;

    // Parse the held byte when the result side has room
    assign advance = item_valid && free;

    darp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    darp_core #(
        .MAX_ANSWER_BYTES (MAX_ANSWER_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .item      (item),
        .emit      (emit),
        .result    (result)
    );

    darp_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (emit),
        .result     (result),
        .free       (free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (out_result)
    );

    assign status       = out_result.status;
    assign server_rcode = out_result.server_rcode;
    assign host_addr    = out_result.host_addr;

    // Address is zero unless the answer parsed cleanly
    a_addr_ok_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != darp_pkg::ST_OK) |-> host_addr == 32'd0)
        else $error("address set on an error result");

    // Rcode is reported only for a server error
    a_rcode_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != darp_pkg::ST_SERVER_RCODE) |-> server_rcode == 4'd0)
        else $error("rcode set on a result that is not a server error");

    // A server error always carries a nonzero rcode
    a_rcode_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == darp_pkg::ST_SERVER_RCODE) |-> server_rcode != 4'd0)
        else $error("server error reported with zero rcode");

endmodule
